[rtl/shfr_pkg.sv]
// ----------------------------------------------------------------------------
// shfr_pkg
// Shared constants and controller/datapath interface types for the
// sync-header frame receiver.
// ----------------------------------------------------------------------------
package shfr_pkg;

  // framing constants
  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam int          IDLE_W        = 17;

  // input beat kinds carried in tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds carried in tuser
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_CSUM_ERR = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic tick_inc;     // count one idle tick
    logic idle_clr;     // byte seen, restart idle count
    logic clr_parser;   // clear fill index and running sum
    logic store_byte;   // write payload byte, advance index and sum
    logic load_err;     // load checksum error result
    logic rd_clr;       // restart payload read index
    logic rd_issue;     // read payload store at read index
    logic load_pay;     // load payload result from read data
    logic rd_next;      // advance read index
  } shfr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic timed_out;    // idle count above timeout
    logic sync_hit;     // incoming byte is a sync byte
    logic fill_last;    // this store completes the payload
    logic sum_ok;       // incoming byte equals inverted sum
    logic out_free;     // output register can take a result
    logic rd_last;      // read index at final payload byte
  } shfr_stat_t;

endpackage

[rtl/sync_header_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_header_frame_receiver
// Parses a byte/tick stream for double 0xFF sync frames with an inverted
// sum checksum; emits payload runs or a checksum error result.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                               tuser               tlast
// s_*      in   [7:0] rx_byte                        op (0 byte, 1 tick) -
// m_*      out  [7:0] payload_byte, [13:8] byte_index kind (1 csum err)  last
// cfg_*    in   cfg_wdata = idle_timeout_ticks, written when cfg_we
//
// a byte or tick beat is taken while the output register is free and no read-out runs
// a good frame emits PAYLOAD_BYTES results, each read from the registered read
// port of the payload store before it is loaded; input is held off meanwhile
// a checksum error is one result loaded with the checksum beat
// rst is synchronous; the payload store has no reset and needs no clear pass
// output stalls hold the result register and back-pressure the input
//
module sync_header_frame_receiver
  import shfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 8
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [13:8] byte_index
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);

  shfr_cmd_t  cmd;
  shfr_stat_t stat;

  // parser controller
  shfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, store and output register
  shfr_datapath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[rtl/shfr_ctrl.sv]
// ----------------------------------------------------------------------------
// shfr_ctrl
// Parser state machine: sync hunting, payload collection, checksum check
// and sequencing of the payload read-out.
// ----------------------------------------------------------------------------
module shfr_ctrl
  import shfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tuser,
  output logic       s_tready,
  input  shfr_stat_t stat,
  output shfr_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_HUNT    = 6'b000001,
    ST_SYNC2   = 6'b000010,
    ST_COLLECT = 6'b000100,
    ST_CHECK   = 6'b001000,
    ST_READ    = 6'b010000,
    ST_LOAD    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  state_t eff_state;
  logic   acc;
  logic   byte_acc;

  // input taken only in parse states with room for an error result
  assign s_tready = (state != ST_READ) && (state != ST_LOAD) && stat.out_free;
  assign acc      = s_tvalid && s_tready;
  assign byte_acc = acc && (s_tuser == OP_BYTE);

  // a timeout sends the byte to sync hunting
  assign eff_state = (byte_acc && stat.timed_out) ? ST_HUNT : state;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.tick_inc   = acc && (s_tuser == OP_TICK);
    cmd.idle_clr   = byte_acc;
    cmd.clr_parser = byte_acc && stat.timed_out;
    if (byte_acc) begin
      unique case (eff_state)
        ST_HUNT: begin
          state_next = stat.sync_hit ? ST_SYNC2 : ST_HUNT;
        end
        ST_SYNC2: begin
          state_next = stat.sync_hit ? ST_COLLECT : ST_SYNC2;
        end
        ST_COLLECT: begin
          cmd.store_byte = 1'b1;
          state_next     = stat.fill_last ? ST_CHECK : ST_COLLECT;
        end
        ST_CHECK: begin
          cmd.clr_parser = 1'b1;
          if (stat.sum_ok) begin
            cmd.rd_clr = 1'b1;
            state_next = ST_READ;
          end else begin
            cmd.load_err = 1'b1;
            state_next   = ST_HUNT;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end else begin
      unique case (state)
        ST_READ: begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_LOAD;
        end
        ST_LOAD: begin
          if (stat.out_free) begin
            cmd.load_pay = 1'b1;
            if (stat.rd_last) begin
              state_next = ST_HUNT;
            end else begin
              cmd.rd_next = 1'b1;
              state_next  = ST_READ;
            end
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/shfr_datapath.sv]
// ----------------------------------------------------------------------------
// shfr_datapath
// Idle tick counter, timeout register, payload store, running sum and the
// result output register.
// ----------------------------------------------------------------------------
module shfr_datapath
  import shfr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 8
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [7:0]  s_tdata,
  input  shfr_cmd_t   cmd,
  output shfr_stat_t  stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [AW-1:0]     LAST_IDX = AW'(PAYLOAD_BYTES - 1);
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  logic [15:0]       timeout;
  logic [IDLE_W-1:0] idle_ticks;
  logic [AW-1:0]     fill_index;
  logic [7:0]        running_sum;
  logic [AW-1:0]     rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        mem [PAYLOAD_BYTES];

  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [5:0]  out_index;
  logic        out_last;

  // status toward the controller
  assign stat.timed_out = idle_ticks > {1'b0, timeout};
  assign stat.sync_hit  = s_tdata == SYNC_BYTE;
  assign stat.fill_last = fill_index == LAST_IDX;
  assign stat.sum_ok    = (~running_sum) == s_tdata;
  assign stat.out_free  = !out_valid || m_tready;
  assign stat.rd_last   = rd_idx == LAST_IDX;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  // saturating idle tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
    end else if (cmd.idle_clr) begin
      idle_ticks <= '0;
    end else if (cmd.tick_inc && (idle_ticks != IDLE_MAX)) begin
      idle_ticks <= idle_ticks + 1'b1;
    end
  end

  // fill index and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index  <= '0;
      running_sum <= '0;
    end else if (cmd.clr_parser) begin
      fill_index  <= '0;
      running_sum <= '0;
    end else if (cmd.store_byte) begin
      fill_index  <= fill_index + 1'b1;
      running_sum <= running_sum + s_tdata;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[fill_index] <= s_tdata;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  // read index for emission
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_clr) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_err || cmd.load_pay) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_kind  <= KIND_CSUM_ERR;
      out_byte  <= '0;
      out_index <= '0;
      out_last  <= 1'b1;
    end else if (cmd.load_pay) begin
      out_kind  <= KIND_PAYLOAD;
      out_byte  <= rd_data;
      out_index <= 6'(rd_idx);
      out_last  <= rd_idx == LAST_IDX;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_index, out_byte};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule
